// ===== design/pid_settle_timeout_controller_assert.svh =====
// ----------------------------------------------------------------------------
// PID settle/timeout controller assertion macros
// Shared property templates, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PID_SETTLE_TIMEOUT_CONTROLLER_ASSERT_SVH
`define PID_SETTLE_TIMEOUT_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define PST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pst: same-cycle check failed");

// Next-cycle implication.
`define PST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pst: next-cycle check failed");

`endif

// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Types, widths and constants shared by the PID settle/timeout controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  localparam int POS_W           = 24;
  localparam int POS_FIELDS      = 6;
  localparam int MOTOR_COUNT_DEF = 6;
  localparam int ERR_W           = 25;
  localparam int DRV_W           = 26;
  localparam int ESUM_W          = 32;
  localparam int TMR_W           = 17;
  localparam int GAIN_W          = 24;
  localparam int SCALE_W         = 16;
  localparam int MS_W            = 16;
  localparam int PWR_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  // Shared multiplier operand A and the PID accumulation widths
  localparam int MA_W          = 33;
  localparam int ACC_W         = 58;
  localparam int S_W           = 48;
  localparam int S_SPLIT       = 24;
  localparam int HI_W          = 40;
  localparam int BIG_W         = 64;
  localparam int MAG_W         = 63;
  localparam int FRAC_SHIFT    = 20;
  localparam int SUM_LIM_SHIFT = 46;

  localparam int ZONE    = 100;
  localparam int TICK_MS = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_OUT_SCALE,
    CFG_SETTLE_BAND,
    CFG_SETTLE_TIME,
    CFG_TIMEOUT
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [SCALE_W-1:0]      output_scale;
    logic [MS_W-1:0]         settle_band;
    logic [MS_W-1:0]         settle_time_ms;
    logic [MS_W-1:0]         timeout_ms;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    target:         24'sd0,
    gain_p:         24'd8520,
    gain_i:         24'd0,
    gain_d:         24'd19661,
    output_scale:   16'd4096,
    settle_band:    16'd5,
    settle_time_ms: 16'd0,
    timeout_ms:     16'd2000
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_ERR,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_ACC,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_COMB,
    ST_ABS,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_DIV,
    MS_P,
    MS_D,
    MS_I,
    MS_HI,
    MS_LO
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     check;
    logic     sum_en;
    logic     div_fix;
    logic     err_calc;
    logic     integ;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     acc_clamp;
    logic     hi_load;
    logic     comb;
    logic     abs_calc;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic sum_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/pst_cfg.sv =====
// ----------------------------------------------------------------------------
// pst_cfg
// Configuration register file, written through the cfg_ request channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_cfg (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [pst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pst_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pst_pkg::cfg_t                     cfg
);
  import pst_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET:      cfg_nxt.target         = $signed(cfg_data);
        CFG_GAIN_P:      cfg_nxt.gain_p         = cfg_data;
        CFG_GAIN_I:      cfg_nxt.gain_i         = cfg_data;
        CFG_GAIN_D:      cfg_nxt.gain_d         = cfg_data;
        CFG_OUT_SCALE:   cfg_nxt.output_scale   = cfg_data[SCALE_W-1:0];
        CFG_SETTLE_BAND: cfg_nxt.settle_band    = cfg_data[MS_W-1:0];
        CFG_SETTLE_TIME: cfg_nxt.settle_time_ms = cfg_data[MS_W-1:0];
        CFG_TIMEOUT:     cfg_nxt.timeout_ms     = cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer for one control tick: stop check, encoder sum, divide, PID terms
// on the shared multiplier, scaling, and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  pst_pkg::dp_stat_t    stat,
  output pst_pkg::dp_cmd_t     cmd
);
  import pst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.stop ? ST_OUT : ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        if (stat.sum_last) begin
          state_nxt = ST_DIV_MUL;
        end
      end
      ST_DIV_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DIV;
        state_nxt   = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_calc = 1'b1;
        state_nxt    = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P;
        state_nxt   = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_D;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_I;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_clamp = 1'b1;
        state_nxt     = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HI;
        state_nxt   = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LO;
        cmd.hi_load = 1'b1;
        state_nxt   = ST_COMB;
      end
      ST_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.abs_calc = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pst_dp.sv =====
// ----------------------------------------------------------------------------
// pst_dp
// Datapath: move state, encoder accumulator, reciprocal divide, shared
// multiplier, PID accumulator, output scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_dp #(
  parameter int MOTOR_COUNT = pst_pkg::MOTOR_COUNT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  pst_pkg::dp_cmd_t                   cmd,
  output pst_pkg::dp_stat_t                  stat,
  input  pst_pkg::cfg_t                      cfg,
  input  wire                                in_start_req,
  input  wire signed [pst_pkg::POS_W-1:0]    pos_in [pst_pkg::POS_FIELDS],
  output logic signed [pst_pkg::PWR_W-1:0]   out_drive_power,
  output logic                               out_finished,
  output logic                               out_timed_out
);
  import pst_pkg::*;

  localparam int CNT_W  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int SUM_W  = POS_W + CNT_W;
  localparam int MB_W   = SUM_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  // floor((2^SUM_W - 1) / N): quotient estimate is exact or one low
  localparam int RECIP  = ((2 ** SUM_W) - 1) / MOTOR_COUNT;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MOTOR_COUNT - 1);
  localparam logic [SUM_W-1:0] DIVISOR  = SUM_W'(MOTOR_COUNT);
  localparam logic signed [ACC_W-1:0] SUM_LIM = ACC_W'(1) << SUM_LIM_SHIFT;
  localparam logic [MAG_W:0] RND_HALF = (MAG_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam int RQ_W = MAG_W + 1 - FRAC_SHIFT;

  function automatic logic [TMR_W-1:0] tmr_tick(input logic [TMR_W-1:0] t);
    logic [TMR_W:0] s;
    s = {1'b0, t} + (TMR_W + 1)'(TICK_MS);
    return s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
  endfunction

  // Captured request
  logic signed [POS_W-1:0] pos_src [MOTOR_COUNT];
  logic signed [POS_W-1:0] pos_r   [MOTOR_COUNT];
  logic                    start_r;

  // Move state
  logic signed [ERR_W-1:0]  last_err_r;
  logic signed [ESUM_W-1:0] esum_r;
  logic [TMR_W-1:0]         settled_r;
  logic [TMR_W-1:0]         running_r;
  logic                     done_r;
  logic                     tflag_r;

  // Working registers
  logic [CNT_W-1:0]         idx_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]         quot_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DRV_W-1:0]  deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [S_W-1:0]    s_r;
  logic signed [HI_W-1:0]   hi_r;
  logic signed [BIG_W-1:0]  big_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic signed [PWR_W-1:0]  power_r;
  logic                     fin_r;
  logic                     tout_r;

  // Stop check
  logic                     eff_done;
  logic                     eff_tflag;
  logic [TMR_W-1:0]         eff_run;
  logic [TMR_W-1:0]         eff_set;
  logic                     trip_to;
  logic                     trip_st;
  logic                     stop_nxt;

  // Divide and error
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         q0;
  logic [SUM_W-1:0]         rem;
  logic signed [SUM_W:0]    avg;
  logic signed [SUM_W+1:0]  err_full;

  // Integral and timers
  logic [ERR_W-1:0]         aerr;
  logic                     in_zone;
  logic                     sign_flip;
  logic signed [ESUM_W:0]   esum_add;
  logic signed [ESUM_W-1:0] esum_sat;

  // Multiplier and scaling
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  s_full;
  logic [MAG_W:0]           rnd;
  logic [RQ_W-1:0]          rq;
  logic signed [PWR_W-1:0]  power_calc;

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_pos
    if (g < POS_FIELDS) begin : g_fld
      assign pos_src[g] = pos_in[g];
    end else begin : g_zero
      assign pos_src[g] = '0;
    end
  end

  // ---- stop check on the state as it stands after an optional clear
  always_comb begin
    eff_done  = start_r ? 1'b0 : done_r;
    eff_tflag = start_r ? 1'b0 : tflag_r;
    eff_run   = start_r ? '0 : running_r;
    eff_set   = start_r ? '0 : settled_r;
    trip_to   = !eff_done && (cfg.timeout_ms != '0) &&
                (eff_run > TMR_W'(cfg.timeout_ms));
    trip_st   = !eff_done && !trip_to && (eff_set > TMR_W'(cfg.settle_time_ms));
    stop_nxt  = eff_done || trip_to || trip_st;
  end

  assign stat.stop     = stop_nxt;
  assign stat.sum_last = (idx_r == LAST_IDX);

  // ---- divide by the motor count
  always_comb begin
    sum_neg  = sum_r[SUM_W-1];
    sum_mag  = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    q0       = prod_r[2*SUM_W-1:SUM_W];
    rem      = sum_mag - SUM_W'(q0 * DIVISOR);
    avg      = sum_neg ? -$signed({1'b0, quot_r}) : $signed({1'b0, quot_r});
    err_full = (SUM_W + 2)'(cfg.target) - (SUM_W + 2)'(avg);
  end

  // ---- integral zone and timers
  always_comb begin
    aerr      = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    in_zone   = aerr < ERR_W'(ZONE);
    sign_flip = (err_r > 0 && last_err_r < 0) || (err_r < 0 && last_err_r > 0);
    esum_add  = (ESUM_W + 1)'(esum_r) + (ESUM_W + 1)'(err_r);
    if (esum_add[ESUM_W] != esum_add[ESUM_W-1]) begin
      esum_sat = esum_add[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                  : {1'b0, {(ESUM_W-1){1'b1}}};
    end else begin
      esum_sat = esum_add[ESUM_W-1:0];
    end
  end

  // ---- shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_DIV: begin
        mul_a = MA_W'(sum_mag);
        mul_b = MB_W'(RECIP);
      end
      MS_P: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(cfg.gain_p);
      end
      MS_D: begin
        mul_a = MA_W'(deriv_r);
        mul_b = MB_W'(cfg.gain_d);
      end
      MS_I: begin
        mul_a = MA_W'(esum_r);
        mul_b = MB_W'(cfg.gain_i);
      end
      MS_HI: begin
        mul_a = MA_W'($signed(s_r[S_W-1:S_SPLIT]));
        mul_b = MB_W'(cfg.output_scale);
      end
      MS_LO: begin
        mul_a = MA_W'(s_r[S_SPLIT-1:0]);
        mul_b = MB_W'(cfg.output_scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---- clamp and round
  always_comb begin
    s_full = acc_r + ACC_W'(prod_r);
    rnd    = {1'b0, mag_r} + RND_HALF;
    rq     = rnd[MAG_W:FRAC_SHIFT];
    if (neg_r) begin
      power_calc = (rq > RQ_W'(32768)) ? {1'b1, {(PWR_W-1){1'b0}}}
                                       : PWR_W'(-$signed({1'b0, rq}));
    end else begin
      power_calc = (rq > RQ_W'(32767)) ? {1'b0, {(PWR_W-1){1'b1}}} : PWR_W'(rq);
    end
  end

  // ---- move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      esum_r     <= '0;
      settled_r  <= '0;
      running_r  <= '0;
      done_r     <= 1'b0;
      tflag_r    <= 1'b0;
    end else if (cmd.check) begin
      if (start_r) begin
        last_err_r <= '0;
        esum_r     <= '0;
        settled_r  <= '0;
        running_r  <= '0;
      end
      done_r  <= stop_nxt;
      tflag_r <= eff_tflag || trip_to;
    end else if (cmd.integ) begin
      last_err_r <= err_r;
      if (sign_flip) begin
        esum_r <= '0;
      end else if (in_zone) begin
        esum_r <= esum_sat;
      end
      settled_r <= (aerr < ERR_W'(cfg.settle_band)) ? tmr_tick(settled_r) : '0;
      running_r <= tmr_tick(running_r);
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r   <= pos_src;
      start_r <= in_start_req;
    end
    if (cmd.check) begin
      idx_r <= '0;
      sum_r <= '0;
    end else if (cmd.sum_en) begin
      sum_r <= sum_r + SUM_W'(pos_r[idx_r]);
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.div_fix) begin
      // correct the one-low estimate
      quot_r <= (rem >= DIVISOR) ? q0 + SUM_W'(1) : q0;
    end
    if (cmd.err_calc) begin
      err_r <= ERR_W'(err_full);
    end
    if (cmd.integ) begin
      deriv_r <= DRV_W'(err_r) - DRV_W'(last_err_r);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc_load) begin
      acc_r <= ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= s_full;
    end
    if (cmd.acc_clamp) begin
      if (s_full > SUM_LIM) begin
        s_r <= S_W'(SUM_LIM);
      end else if (s_full < -SUM_LIM) begin
        s_r <= S_W'(-SUM_LIM);
      end else begin
        s_r <= S_W'(s_full);
      end
    end
    if (cmd.hi_load) begin
      hi_r <= HI_W'(prod_r);
    end
    if (cmd.comb) begin
      big_r <= (BIG_W'(hi_r) <<< S_SPLIT) + BIG_W'(prod_r);
    end
    if (cmd.abs_calc) begin
      neg_r <= big_r[BIG_W-1];
      mag_r <= big_r[BIG_W-1] ? MAG_W'(-big_r) : MAG_W'(big_r);
    end
    if (cmd.load_out) begin
      power_r <= done_r ? '0 : power_calc;
      fin_r   <= done_r;
      tout_r  <= tflag_r;
    end
  end

  assign out_drive_power = power_r;
  assign out_finished    = fin_r;
  assign out_timed_out   = tout_r;

endmodule

`default_nettype wire

// ===== design/pid_settle_timeout_controller.sv =====
// ----------------------------------------------------------------------------
// pid_settle_timeout_controller
// Fixed-point PID drive controller with integral zone, settle timer and
// timeout; one request is one control tick of six encoder positions.
// ----------------------------------------------------------------------------
// One tick is in flight at a time: a tick on a running move runs from
// acceptance through the sum, divide, PID and scaling states before the next
// request can be taken. The encoder sum adds one position per cycle, then
// the divide, the three PID terms and the two halves of the output scaling
// each take a turn on a single 33 x 28 bit multiplier. A tick that finds the
// move stopped, or stops it, goes from the stop check straight to the output.
// The result sits in an output register, so a new request is accepted while it
// waits for out_ready; the next result is held back only while that register is
// still full. Configuration writes are taken every cycle and belong between ticks.
`default_nettype none

module pid_settle_timeout_controller #(
  parameter int MOTOR_COUNT = pst_pkg::MOTOR_COUNT_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_start_req,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_left_front,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_left_middle,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_left_back,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_right_front,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_right_middle,
  input  wire signed [pst_pkg::POS_W-1:0]   in_pos_right_back,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [pst_pkg::PWR_W-1:0]  out_drive_power,
  output logic                              out_finished,
  output logic                              out_timed_out,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [pst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pst_pkg::*;

  cfg_t                    cfg;
  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic signed [POS_W-1:0] pos_in [POS_FIELDS];

  assign pos_in[0] = in_pos_left_front;
  assign pos_in[1] = in_pos_left_middle;
  assign pos_in[2] = in_pos_left_back;
  assign pos_in[3] = in_pos_right_front;
  assign pos_in[4] = in_pos_right_middle;
  assign pos_in[5] = in_pos_right_back;

  pst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pst_dp #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .in_start_req    (in_start_req),
    .pos_in          (pos_in),
    .out_drive_power (out_drive_power),
    .out_finished    (out_finished),
    .out_timed_out   (out_timed_out)
  );

endmodule

`default_nettype wire

// ===== design/pst_checker.sv =====
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks for the PID settle/timeout controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_settle_timeout_controller_assert.svh"

module pst_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [15:0] out_drive_power,
  input wire               out_finished,
  input wire               out_timed_out
);

  // Stalled result holds.
  `PST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive_power) && $stable(out_finished) && $stable(out_timed_out))

  // A stopped move drives nothing.
  `PST_ASSERT_IMP(a_fin_zero, out_valid && out_finished, out_drive_power == 16'sd0)

  // Timeout is only ever a reason for a stop.
  `PST_ASSERT_IMP(a_to_fin, out_valid && out_timed_out, out_finished)

  // A fresh result frees the input side in the same cycle.
  `PST_ASSERT_IMP(a_rose_ready, $rose(out_valid), in_ready)

endmodule

bind pid_settle_timeout_controller pst_checker u_pst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_drive_power (out_drive_power),
  .out_finished    (out_finished),
  .out_timed_out   (out_timed_out)
);

`default_nettype wire

// ===== bench/pid_settle_timeout_controller_test.sv =====
// ----------------------------------------------------------------------------
// pid_settle_timeout_controller_test
// Self-checking bench for the PID settle/timeout controller. A queue-fed
// driver offers control ticks, a monitor checks every drive result against a
// cycle-free fixed-point predictor, and register settings change between
// phases of directed, extreme and randomized moves.
// ----------------------------------------------------------------------------
module pid_settle_timeout_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  typedef struct packed {
    logic                        start;
    logic [POS_FIELDS-1:0][POS_W-1:0] pos;
  } tick_t;

  typedef struct packed {
    logic signed [PWR_W-1:0] power;
    logic                    finished;
    logic                    timed_out;
  } drive_t;

  localparam longint ACC_HI    = 64'sd2147483647;
  localparam longint ACC_LO    = -64'sd2147483648;
  localparam longint S_CLAMP   = 64'sd1 <<< SUM_LIM_SHIFT;
  localparam longint POS_HI    = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_LO    = -(64'sd1 <<< (POS_W - 1));
  localparam longint TIMER_TOP = (64'sd1 <<< TMR_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_start_req = 1'b0;
  logic [POS_W-1:0]      in_pos_left_front = '0;
  logic [POS_W-1:0]      in_pos_left_middle = '0;
  logic [POS_W-1:0]      in_pos_left_back = '0;
  logic [POS_W-1:0]      in_pos_right_front = '0;
  logic [POS_W-1:0]      in_pos_right_middle = '0;
  logic [POS_W-1:0]      in_pos_right_back = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [PWR_W-1:0] out_drive_power;
  logic                  out_finished;
  logic                  out_timed_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_settle_timeout_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_req        (in_start_req),
    .in_pos_left_front   (in_pos_left_front),
    .in_pos_left_middle  (in_pos_left_middle),
    .in_pos_left_back    (in_pos_left_back),
    .in_pos_right_front  (in_pos_right_front),
    .in_pos_right_middle (in_pos_right_middle),
    .in_pos_right_back   (in_pos_right_back),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_power     (out_drive_power),
    .out_finished        (out_finished),
    .out_timed_out       (out_timed_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor copy of the register file
  longint c_target = longint'(CFG_RST.target);
  longint c_kp     = longint'(CFG_RST.gain_p);
  longint c_ki     = longint'(CFG_RST.gain_i);
  longint c_kd     = longint'(CFG_RST.gain_d);
  longint c_scale  = longint'(CFG_RST.output_scale);
  longint c_band   = longint'(CFG_RST.settle_band);
  longint c_settle = longint'(CFG_RST.settle_time_ms);
  longint c_tmo    = longint'(CFG_RST.timeout_ms);

  // Predictor copy of the move state
  longint last_err = 0;
  longint err_acc = 0;
  longint settle_ms = 0;
  longint run_ms = 0;
  bit     stopped = 1'b0;
  bit     stop_timeout = 1'b0;

  tick_t  pending_ticks[$];
  drive_t expected_drive[$];
  tick_t  tick_now;
  drive_t want;

  logic [CFG_DATA_W-1:0] reg_val [8];
  bit                    reg_pick [8];

  int  tx_gap = 0;
  int  rx_gap = 0;
  int  idle_pct = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  mismatches = 0;
  int  ticks_taken = 0;
  int  results_seen = 0;
  int  stops_seen = 0;
  int  timeouts_seen = 0;
  int  clipped_seen = 0;
  int  settings_used = 0;

  function automatic longint timer_tick(longint t);
    return (t + TICK_MS > TIMER_TOP) ? TIMER_TOP : t + TICK_MS;
  endfunction

  // One control tick of the controller, bit exact
  function automatic drive_t predict_tick(tick_t t);
    drive_t r;
    longint pos_sum, avg, err, deriv, aerr, s, prod, mag;
    int     m;
    pos_sum = 0;
    r = '0;
    if (t.start) begin
      last_err = 0;
      err_acc = 0;
      settle_ms = 0;
      run_ms = 0;
      stopped = 1'b0;
      stop_timeout = 1'b0;
    end
    if (!stopped) begin
      if (c_tmo != 0 && run_ms > c_tmo) begin
        stopped = 1'b1;
        stop_timeout = 1'b1;
      end else if (settle_ms > c_settle) begin
        stopped = 1'b1;
      end
    end
    if (stopped) begin
      r.finished = 1'b1;
      r.timed_out = stop_timeout;
      return r;
    end
    for (m = 0; m < POS_FIELDS; m++)
      pos_sum += longint'($signed(t.pos[m]));
    avg = pos_sum / MOTOR_COUNT_DEF;
    err = c_target - avg;
    deriv = err - last_err;
    aerr = (err < 0) ? -err : err;
    if (aerr < ZONE) begin
      err_acc += err;
      if (err_acc > ACC_HI) err_acc = ACC_HI;
      if (err_acc < ACC_LO) err_acc = ACC_LO;
    end
    // opposite sign from last tick: drop the integral
    if ((err > 0 && last_err < 0) || (err < 0 && last_err > 0))
      err_acc = 0;
    s = err * c_kp + deriv * c_kd + err_acc * c_ki;
    if (s > S_CLAMP) s = S_CLAMP;
    if (s < -S_CLAMP) s = -S_CLAMP;
    prod = s * c_scale;
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    if (prod < 0)
      r.power = (mag > 32768) ? -16'sd32768 : PWR_W'(-mag);
    else
      r.power = (mag > 32767) ? 16'sd32767 : PWR_W'(mag);
    last_err = err;
    settle_ms = (aerr < c_band) ? timer_tick(settle_ms) : 0;
    run_ms = timer_tick(run_ms);
    return r;
  endfunction

  function automatic tick_t mk_tick(logic st, logic [POS_W-1:0] a, b, c, d, e, f);
    tick_t t;
    t.start = st;
    t.pos[0] = a;
    t.pos[1] = b;
    t.pos[2] = c;
    t.pos[3] = d;
    t.pos[4] = e;
    t.pos[5] = f;
    return t;
  endfunction

  // Request driver: holds each tick until taken, idles in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_drive.push_back(predict_tick(tick_now));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (!calm && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
          tx_gap = $urandom_range(14, 0);
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          tick_now = pending_ticks.pop_front();
          in_valid <= 1'b1;
          in_start_req <= tick_now.start;
          in_pos_left_front <= tick_now.pos[0];
          in_pos_left_middle <= tick_now.pos[1];
          in_pos_left_back <= tick_now.pos[2];
          in_pos_right_front <= tick_now.pos[3];
          in_pos_right_middle <= tick_now.pos[4];
          in_pos_right_back <= tick_now.pos[5];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_finished) stops_seen++;
        if (out_timed_out) timeouts_seen++;
        if (!out_finished && (out_drive_power == 16'sd32767 || out_drive_power == -16'sd32768))
          clipped_seen++;
        if (expected_drive.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: power %0d finished %0b timed_out %0b",
                     out_drive_power, out_finished, out_timed_out);
        end else begin
          want = expected_drive.pop_front();
          if (out_drive_power !== want.power || out_finished !== want.finished ||
              out_timed_out !== want.timed_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected power %0d finished %0b timed_out %0b, %s %0d %0b %0b",
                       results_seen, want.power, want.finished, want.timed_out,
                       "got", out_drive_power, out_finished, out_timed_out);
          end
        end
      end
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!calm && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        rx_gap = $urandom_range(14, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    repeat (400) @(posedge clk);
    hold_done <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("pid_settle_timeout_controller_test failed");
    $finish;
  end

  // Write the picked registers back to back; call at a clock edge
  task automatic program_regs();
    int i;
    for (i = 0; i <= int'(CFG_TIMEOUT); i++) begin
      if (reg_pick[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_idx_t'(i);
        cfg_data <= reg_val[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (cfg_idx_t'(i))
          CFG_TARGET:      c_target = longint'($signed(reg_val[i]));
          CFG_GAIN_P:      c_kp = longint'(reg_val[i]);
          CFG_GAIN_I:      c_ki = longint'(reg_val[i]);
          CFG_GAIN_D:      c_kd = longint'(reg_val[i]);
          CFG_OUT_SCALE:   c_scale = longint'(reg_val[i][SCALE_W-1:0]);
          CFG_SETTLE_BAND: c_band = longint'(reg_val[i][MS_W-1:0]);
          CFG_SETTLE_TIME: c_settle = longint'(reg_val[i][MS_W-1:0]);
          CFG_TIMEOUT:     c_tmo = longint'(reg_val[i][MS_W-1:0]);
          default: ;
        endcase
        reg_pick[i] = 1'b0;
      end
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Hold until every queued tick is taken and every result is back
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || expected_drive.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_noise(int cnt);
    tick_t t;
    int    k, m;
    for (k = 0; k < cnt; k++) begin
      t.start = ($urandom_range(3, 0) == 0);
      for (m = 0; m < POS_FIELDS; m++)
        t.pos[m] = POS_W'($urandom());
      pending_ticks.push_back(t);
    end
  endtask

  // A move that rings around the target and decays toward it
  task automatic queue_move(int len);
    tick_t  t;
    longint off, v;
    int     k, m;
    off = longint'($urandom_range(4000, 0)) - 2000;
    for (k = 0; k < len; k++) begin
      t.start = (k == 0) && ($urandom_range(9, 0) != 0);
      for (m = 0; m < POS_FIELDS; m++) begin
        v = c_target + off + longint'($urandom_range(6, 0)) - 3;
        if (v > POS_HI) v = POS_HI;
        if (v < POS_LO) v = POS_LO;
        t.pos[m] = v[POS_W-1:0];
      end
      pending_ticks.push_back(t);
      off = -(off * longint'($urandom_range(8, 2))) / 10;
    end
  endtask

  task automatic pick_random_regs();
    int i;
    reg_val[CFG_TARGET] = ($urandom_range(9, 0) == 0) ? POS_W'($urandom()) :
                          POS_W'(int'($urandom_range(4000, 0)) - 2000);
    reg_val[CFG_GAIN_P] = ($urandom_range(6, 0) == 0) ? GAIN_W'($urandom()) :
                          GAIN_W'($urandom_range(70000, 0));
    reg_val[CFG_GAIN_I] = ($urandom_range(6, 0) == 0) ? GAIN_W'($urandom()) :
                          GAIN_W'($urandom_range(20000, 0));
    reg_val[CFG_GAIN_D] = ($urandom_range(6, 0) == 0) ? GAIN_W'($urandom()) :
                          GAIN_W'($urandom_range(70000, 0));
    reg_val[CFG_OUT_SCALE] = ($urandom_range(6, 0) == 0) ? CFG_DATA_W'($urandom_range(65535, 0)) :
                             CFG_DATA_W'($urandom_range(16384, 512));
    reg_val[CFG_SETTLE_BAND] = ($urandom_range(9, 0) == 0) ? CFG_DATA_W'(65535) :
                               CFG_DATA_W'($urandom_range(40, 0));
    reg_val[CFG_SETTLE_TIME] = CFG_DATA_W'($urandom_range(150, 0));
    reg_val[CFG_TIMEOUT] = ($urandom_range(4, 0) == 0) ? '0 :
                           CFG_DATA_W'($urandom_range(400, 10));
    for (i = 0; i <= int'(CFG_TIMEOUT); i++)
      reg_pick[i] = ($urandom_range(3, 0) != 0);
  endtask

  initial begin
    int rand_ticks, phase, n, len;
    rand_ticks = 0;
    phase = 0;
    foreach (reg_pick[i]) reg_pick[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a tick inside the band stops the next one on settle
    pending_ticks.push_back(mk_tick(1, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, '1, '1, '1, '1, '1, '1));
    wait_idle();

    // Field extremes and truncating average, never settling
    reg_val[CFG_SETTLE_TIME] = 24'h00FFFF;
    reg_pick[CFG_SETTLE_TIME] = 1'b1;
    program_regs();
    pending_ticks.push_back(mk_tick(1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    pending_ticks.push_back(mk_tick(0, 24'h800000, 24'h800000, 24'h800000,
                                    24'h800000, 24'h800000, 24'h800000));
    pending_ticks.push_back(mk_tick(0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                    24'h800000, 24'h7FFFFF, 24'h800000));
    pending_ticks.push_back(mk_tick(0, '1, '1, '1, '1, '1, 24'hFFFFF9));
    pending_ticks.push_back(mk_tick(0, '1, 24'hFFFFFE, '1, '1, '1, '1));
    pending_ticks.push_back(mk_tick(0, 24'h555555, 24'h555555, 24'h555555,
                                    24'h555555, 24'h555555, 24'h555555));
    pending_ticks.push_back(mk_tick(0, 24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
                                    24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA));
    pending_ticks.push_back(mk_tick(1, 24'd50, 24'd50, 24'd50, 24'd50, 24'd50, 24'd50));
    pending_ticks.push_back(mk_tick(0, 24'hFFFFCE, 24'hFFFFCE, 24'hFFFFCE,
                                    24'hFFFFCE, 24'hFFFFCE, 24'hFFFFCE));
    wait_idle();

    // Integral zone, sign flip, timeout stop, sticky timeout, restart
    reg_val[CFG_GAIN_I] = 24'd30000;
    reg_val[CFG_TIMEOUT] = 24'd30;
    reg_pick[CFG_GAIN_I] = 1'b1;
    reg_pick[CFG_TIMEOUT] = 1'b1;
    program_regs();
    pending_ticks.push_back(mk_tick(1, 24'd20, 24'd20, 24'd20, 24'd20, 24'd20, 24'd20));
    pending_ticks.push_back(mk_tick(0, 24'd10, 24'd10, 24'd10, 24'd10, 24'd10, 24'd10));
    pending_ticks.push_back(mk_tick(0, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5));
    pending_ticks.push_back(mk_tick(0, 24'hFFFFFD, 24'hFFFFFD, 24'hFFFFFD,
                                    24'hFFFFFD, 24'hFFFFFD, 24'hFFFFFD));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 24'd1));
    wait_idle();

    // Timeout and settle trip on the same tick: timeout must win
    reg_val[CFG_TIMEOUT] = 24'd5;
    reg_val[CFG_SETTLE_BAND] = 24'h00FFFF;
    reg_val[CFG_SETTLE_TIME] = '0;
    reg_pick[CFG_TIMEOUT] = 1'b1;
    reg_pick[CFG_SETTLE_BAND] = 1'b1;
    reg_pick[CFG_SETTLE_TIME] = 1'b1;
    program_regs();
    pending_ticks.push_back(mk_tick(1, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Every register at its top value
    reg_val[CFG_TARGET] = 24'h7FFFFF;
    reg_val[CFG_GAIN_P] = '1;
    reg_val[CFG_GAIN_I] = '1;
    reg_val[CFG_GAIN_D] = '1;
    reg_val[CFG_OUT_SCALE] = 24'h00FFFF;
    reg_val[CFG_SETTLE_BAND] = 24'h00FFFF;
    reg_val[CFG_SETTLE_TIME] = 24'h00FFFF;
    reg_val[CFG_TIMEOUT] = 24'h00FFFF;
    foreach (reg_pick[i]) reg_pick[i] = 1'b1;
    program_regs();
    pending_ticks.push_back(mk_tick(1, 24'h800000, 24'h800000, 24'h800000,
                                    24'h800000, 24'h800000, 24'h800000));
    queue_noise(10);
    wait_idle();

    // Every register at its bottom value: timeout off, band never met
    reg_val[CFG_TARGET] = 24'h800000;
    foreach (reg_val[i]) if (i != int'(CFG_TARGET)) reg_val[i] = '0;
    foreach (reg_pick[i]) reg_pick[i] = 1'b1;
    program_regs();
    pending_ticks.push_back(mk_tick(1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    queue_noise(10);
    wait_idle();

    // Randomized phases: mostly well-formed moves, some noise
    while (rand_ticks < 880) begin
      pick_random_regs();
      program_regs();
      case ($urandom_range(2, 0))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      calm = (rand_ticks >= 800);
      n = 0;
      while (n < 45) begin
        if ($urandom_range(99, 0) < 85) begin
          len = $urandom_range(30, 2);
          queue_move(len);
          n += len;
        end else begin
          queue_noise(1);
          n++;
        end
      end
      rand_ticks += n;
      if (phase == 2)
        hold_go <= 1'b1;
      wait_idle();
      phase++;
    end

    repeat (40) @(posedge clk);
    $display("covered %0d control ticks over %0d register settings, %0d results checked",
             ticks_taken, settings_used, results_seen);
    $display("stopped results %0d (%0d by timeout), drive at its limits %0d times",
             stops_seen, timeouts_seen, clipped_seen);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("pid_settle_timeout_controller_test passed");
    end else begin
      $display("pid_settle_timeout_controller_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pst_pkg.sv
design/pst_cfg.sv
design/pst_ctrl.sv
design/pst_dp.sv
design/pid_settle_timeout_controller.sv
design/pst_checker.sv
bench/pid_settle_timeout_controller_test.sv
